FILE: rtl/tgt_pkg.sv
// shared types and constants for the touch gesture tracker
package tgt_pkg;

    localparam int FIELD_W   = 12;
    localparam int CMD_DEPTH = 4;
    localparam int PTR_W     = $clog2(CMD_DEPTH);

    typedef enum logic [2:0] {
        EV_TOUCH_DOWN = 3'd0,
        EV_TOUCH_DRAG = 3'd1,
        EV_TOUCH_UP   = 3'd2,
        EV_PINCH_DOWN = 3'd3,
        EV_PINCH_DRAG = 3'd4,
        EV_PINCH_UP   = 3'd5
    } ev_kind_t;

    // one accepted word that causes one or two events
    typedef struct packed {
        ev_kind_t               kind0;
        logic [FIELD_W-1:0]     a0_x;
        logic [FIELD_W-1:0]     a0_y;
        logic [FIELD_W-1:0]     b0_x;
        logic [FIELD_W-1:0]     b0_y;
        logic                   has1;
        ev_kind_t               kind1;
        logic [FIELD_W-1:0]     a1_x;
        logic [FIELD_W-1:0]     a1_y;
    } tgt_cmd_t;

endpackage

FILE: rtl/tgt_front.sv
// front end: saturates coordinates, tracks gesture state, builds event commands
module tgt_front
    import tgt_pkg::*;
#(
    parameter int COORD_WIDTH = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               fifo_full,
    input  logic               first_down,
    input  logic               second_down,
    input  logic [FIELD_W-1:0] first_x,
    input  logic [FIELD_W-1:0] first_y,
    input  logic [FIELD_W-1:0] second_x,
    input  logic [FIELD_W-1:0] second_y,
    output logic               fifo_push,
    output tgt_cmd_t           cmd
);

    localparam int CMAX_INT = (COORD_WIDTH >= FIELD_W) ? ((1 << FIELD_W) - 1)
                                                       : ((1 << COORD_WIDTH) - 1);
    localparam logic [FIELD_W-1:0] COORD_MAX = FIELD_W'(CMAX_INT);

    logic               touched_reg, touched_next;
    logic               pinched_reg, pinched_next;
    logic [FIELD_W-1:0] ha_x_reg, ha_x_next;
    logic [FIELD_W-1:0] ha_y_reg, ha_y_next;
    logic [FIELD_W-1:0] hb_x_reg, hb_x_next;
    logic [FIELD_W-1:0] hb_y_reg, hb_y_next;

    logic               accept;
    logic               has0;
    logic [FIELD_W-1:0] ax, ay, bx, by;

    assign accept    = push && !fifo_full;
    assign fifo_push = accept && has0;

    assign ax = (first_x  > COORD_MAX) ? COORD_MAX : first_x;
    assign ay = (first_y  > COORD_MAX) ? COORD_MAX : first_y;
    assign bx = (second_x > COORD_MAX) ? COORD_MAX : second_x;
    assign by = (second_y > COORD_MAX) ? COORD_MAX : second_y;

    always_comb
    begin
        touched_next = touched_reg;
        pinched_next = pinched_reg;
        ha_x_next    = ha_x_reg;
        ha_y_next    = ha_y_reg;
        hb_x_next    = hb_x_reg;
        hb_y_next    = hb_y_reg;
        has0         = 1'b0;
        cmd          = '0;
        cmd.kind0    = EV_TOUCH_DOWN;
        cmd.kind1    = EV_TOUCH_UP;

        if (first_down && second_down)
        begin
            if (!pinched_reg || ax != ha_x_reg || ay != ha_y_reg
                || bx != hb_x_reg || by != hb_y_reg)
            begin
                pinched_next = 1'b1;
                ha_x_next    = ax;
                ha_y_next    = ay;
                hb_x_next    = bx;
                hb_y_next    = by;
                has0         = 1'b1;
                cmd.kind0    = pinched_reg ? EV_PINCH_DRAG : EV_PINCH_DOWN;
                cmd.a0_x     = ax;
                cmd.a0_y     = ay;
                cmd.b0_x     = bx;
                cmd.b0_y     = by;
            end
        end
        else if (first_down)
        begin
            if (pinched_reg)
            begin
                // leaving a pinch keeps the first position, no touch event
                pinched_next = 1'b0;
                hb_x_next    = bx;
                hb_y_next    = by;
                has0         = 1'b1;
                cmd.kind0    = EV_PINCH_UP;
                cmd.a0_x     = ha_x_reg;
                cmd.a0_y     = ha_y_reg;
                cmd.b0_x     = bx;
                cmd.b0_y     = by;
            end
            else if (!touched_reg || ax != ha_x_reg || ay != ha_y_reg)
            begin
                touched_next = 1'b1;
                ha_x_next    = ax;
                ha_y_next    = ay;
                has0         = 1'b1;
                cmd.kind0    = touched_reg ? EV_TOUCH_DRAG : EV_TOUCH_DOWN;
                cmd.a0_x     = ax;
                cmd.a0_y     = ay;
            end
        end
        else
        begin
            pinched_next = 1'b0;
            touched_next = 1'b0;
            if (pinched_reg)
            begin
                hb_x_next = bx;
                hb_y_next = by;
                has0      = 1'b1;
                cmd.kind0 = EV_PINCH_UP;
                cmd.a0_x  = ha_x_reg;
                cmd.a0_y  = ha_y_reg;
                cmd.b0_x  = bx;
                cmd.b0_y  = by;
            end
            if (touched_reg)
            begin
                ha_x_next = ax;
                ha_y_next = ay;
                if (pinched_reg)
                begin
                    // full release out of a pinch: touch up goes second
                    cmd.has1 = 1'b1;
                    cmd.kind1 = EV_TOUCH_UP;
                    cmd.a1_x = ax;
                    cmd.a1_y = ay;
                end
                else
                begin
                    has0      = 1'b1;
                    cmd.kind0 = EV_TOUCH_UP;
                    cmd.a0_x  = ax;
                    cmd.a0_y  = ay;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touched_reg <= 1'b0;
            pinched_reg <= 1'b0;
            ha_x_reg    <= '0;
            ha_y_reg    <= '0;
            hb_x_reg    <= '0;
            hb_y_reg    <= '0;
        end
        else if (accept)
        begin
            touched_reg <= touched_next;
            pinched_reg <= pinched_next;
            ha_x_reg    <= ha_x_next;
            ha_y_reg    <= ha_y_next;
            hb_x_reg    <= hb_x_next;
            hb_y_reg    <= hb_y_next;
        end
    end

endmodule

FILE: rtl/tgt_cmd_fifo.sv
// short command queue between the front end and the event sequencer
module tgt_cmd_fifo
    import tgt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  tgt_cmd_t wr_cmd,
    input  logic     rd_en,
    output tgt_cmd_t rd_cmd,
    output logic     full,
    output logic     empty
);

    tgt_cmd_t         entry_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full   = (count_reg == (PTR_W+1)'(CMD_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/tgt_back.sv
// back end: walks the events of the head command onto the result ports
module tgt_back
    import tgt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  tgt_cmd_t           head,
    input  logic               fifo_empty,
    output logic               fifo_pop,
    input  logic               pop,
    output logic               empty,
    output logic [2:0]         event_kind,
    output logic [FIELD_W-1:0] pos_a_x,
    output logic [FIELD_W-1:0] pos_a_y,
    output logic [FIELD_W-1:0] pos_b_x,
    output logic [FIELD_W-1:0] pos_b_y,
    output logic               last_of_run
);

    logic phase_reg;
    logic phase_next;
    logic take;

    assign empty       = fifo_empty;
    assign take        = pop && !fifo_empty;
    assign last_of_run = phase_reg || !head.has1;
    assign fifo_pop    = take && last_of_run;

    // second slot is always a touch event, so its second position reads zero
    assign event_kind = phase_reg ? head.kind1 : head.kind0;
    assign pos_a_x    = phase_reg ? head.a1_x : head.a0_x;
    assign pos_a_y    = phase_reg ? head.a1_y : head.a0_y;
    assign pos_b_x    = phase_reg ? '0 : head.b0_x;
    assign pos_b_y    = phase_reg ? '0 : head.b0_y;

    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            phase_next = !last_of_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

FILE: rtl/touch_gesture_tracker_unit.sv
// top level of the touch gesture tracker
// Each word pushed is one touch-controller interrupt with the down flags and
// coordinates of two contacts; each word popped is one gesture event (touch or
// pinch down, drag, up) with the held positions, last_of_run marking the final
// event of an interrupt. An interrupt is taken whenever full is low, and the
// front end classifies it against the tracked state at once; the commands
// wait in a four-entry command queue, and the back end hands out one event
// word per cycle while pop is high and empty is low, so an interrupt yields
// one or two words (two only on a full release out of a pinch), or none if
// it causes no event. Coordinates above the COORD_WIDTH range saturate.
module touch_gesture_tracker_unit
    import tgt_pkg::*;
#(
    parameter int COORD_WIDTH = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               first_down,
    input  logic               second_down,
    input  logic [FIELD_W-1:0] first_x,
    input  logic [FIELD_W-1:0] first_y,
    input  logic [FIELD_W-1:0] second_x,
    input  logic [FIELD_W-1:0] second_y,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         event_kind,
    output logic [FIELD_W-1:0] pos_a_x,
    output logic [FIELD_W-1:0] pos_a_y,
    output logic [FIELD_W-1:0] pos_b_x,
    output logic [FIELD_W-1:0] pos_b_y,
    output logic               last_of_run
);

    tgt_cmd_t front_cmd;
    tgt_cmd_t head_cmd;
    logic     fifo_push;
    logic     fifo_pop;
    logic     fifo_full;
    logic     fifo_empty;

    assign full = fifo_full;

    tgt_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .fifo_full   (fifo_full),
        .first_down  (first_down),
        .second_down (second_down),
        .first_x     (first_x),
        .first_y     (first_y),
        .second_x    (second_x),
        .second_y    (second_y),
        .fifo_push   (fifo_push),
        .cmd         (front_cmd)
    );

    tgt_cmd_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (fifo_push),
        .wr_cmd (front_cmd),
        .rd_en  (fifo_pop),
        .rd_cmd (head_cmd),
        .full   (fifo_full),
        .empty  (fifo_empty)
    );

    tgt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_cmd),
        .fifo_empty  (fifo_empty),
        .fifo_pop    (fifo_pop),
        .pop         (pop),
        .empty       (empty),
        .event_kind  (event_kind),
        .pos_a_x     (pos_a_x),
        .pos_a_y     (pos_a_y),
        .pos_b_x     (pos_b_x),
        .pos_b_y     (pos_b_y),
        .last_of_run (last_of_run)
    );

endmodule

FILE: rtl/tgt_checker.sv
// port-level checks for the touch gesture tracker and their bind
module tgt_checker
    import tgt_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input logic [2:0]         event_kind,
    input logic [FIELD_W-1:0] pos_b_x,
    input logic [FIELD_W-1:0] pos_b_y,
    input logic               last_of_run
);

    // only a pinch up can be followed by another event of the same interrupt
    a_first_of_two_is_pinch_up: assert property (
        @(posedge clk) disable iff (!rst_n)
        !empty && !last_of_run |-> event_kind == EV_PINCH_UP)
        else $error("non-final event is not a pinch up");

    a_second_is_touch_up: assert property (
        @(posedge clk) disable iff (!rst_n)
        !empty && pop && !last_of_run |=>
            !empty && event_kind == EV_TOUCH_UP && last_of_run)
        else $error("pinch up on release not followed by final touch up");

    a_touch_has_no_second: assert property (
        @(posedge clk) disable iff (!rst_n)
        !empty && (event_kind == EV_TOUCH_DOWN || event_kind == EV_TOUCH_DRAG
            || event_kind == EV_TOUCH_UP) |-> pos_b_x == '0 && pos_b_y == '0)
        else $error("touch event carries a second position");

    a_stall_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(event_kind) && $stable(last_of_run))
        else $error("waiting event word changed");

endmodule

bind touch_gesture_tracker_unit tgt_checker u_tgt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .event_kind  (event_kind),
    .pos_b_x     (pos_b_x),
    .pos_b_y     (pos_b_y),
    .last_of_run (last_of_run)
);

FILE: bench/tb_touch_gesture_tracker_unit.sv
// testbench for the touch gesture tracker unit
`timescale 1ns / 100ps

module tb_touch_gesture_tracker_unit;
    import tgt_pkg::*;

    localparam int COORD_W      = 12;
    localparam int COORD_TOP    = (1 << COORD_W) - 1;
    localparam int MAX_CYCLES   = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_PRINTS   = 30;

    typedef logic [FIELD_W-1:0] coord_t;

    typedef struct packed {
        logic   d1;
        logic   d2;
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
    } irq_t;

    typedef struct packed {
        ev_kind_t kind;
        coord_t   ax;
        coord_t   ay;
        coord_t   bx;
        coord_t   by;
        logic     last;
    } gesture_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic               first_down;
    logic               second_down;
    logic [FIELD_W-1:0] first_x;
    logic [FIELD_W-1:0] first_y;
    logic [FIELD_W-1:0] second_x;
    logic [FIELD_W-1:0] second_y;
    logic               empty;
    logic               pop;
    logic [2:0]         event_kind;
    logic [FIELD_W-1:0] pos_a_x;
    logic [FIELD_W-1:0] pos_a_y;
    logic [FIELD_W-1:0] pos_b_x;
    logic [FIELD_W-1:0] pos_b_y;
    logic               last_of_run;

    // tracked gesture state
    logic   trk_touched;
    logic   trk_pinched;
    coord_t trk_ax;
    coord_t trk_ay;
    coord_t trk_bx;
    coord_t trk_by;

    irq_t     irq_backlog[$];
    gesture_t gestures_due[$];

    int irqs_queued;
    int irqs_taken;
    int events_checked;
    int errors;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    bit hold_req;
    bit irq_fire;
    int kind_hits[6];

    touch_gesture_tracker_unit i_dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d of %0d words taken",
                     cycles, irqs_taken, irqs_queued);
            $display("tb_touch_gesture_tracker_unit NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycles, what, got, want);
    endtask

    function automatic coord_t clip(input coord_t c);
        return (c > COORD_TOP) ? coord_t'(COORD_TOP) : c;
    endfunction

    function automatic gesture_t snap(input ev_kind_t kind, input bit with_b);
        gesture_t g;
        g.kind = kind;
        g.ax   = trk_ax;
        g.ay   = trk_ay;
        g.bx   = with_b ? trk_bx : '0;
        g.by   = with_b ? trk_by : '0;
        g.last = 1'b0;
        return g;
    endfunction

    task automatic track_gesture(input irq_t irq);
        coord_t   ax;
        coord_t   ay;
        coord_t   bx;
        coord_t   by;
        gesture_t evs[2];
        int       n;
        ax = clip(irq.ax);
        ay = clip(irq.ay);
        bx = clip(irq.bx);
        by = clip(irq.by);
        n  = 0;
        if (irq.d1 && irq.d2)
        begin
            if (!trk_pinched || ax != trk_ax || ay != trk_ay || bx != trk_bx || by != trk_by)
            begin
                trk_ax = ax;
                trk_ay = ay;
                trk_bx = bx;
                trk_by = by;
                evs[n] = snap(trk_pinched ? EV_PINCH_DRAG : EV_PINCH_DOWN, 1'b1);
                n++;
                trk_pinched = 1'b1;
            end
        end
        else if (irq.d1)
        begin
            if (trk_pinched)
            begin
                // second finger lifted, first stays where it was held
                trk_pinched = 1'b0;
                trk_bx = bx;
                trk_by = by;
                evs[n] = snap(EV_PINCH_UP, 1'b1);
                n++;
            end
            else if (!trk_touched || ax != trk_ax || ay != trk_ay)
            begin
                trk_ax = ax;
                trk_ay = ay;
                evs[n] = snap(trk_touched ? EV_TOUCH_DRAG : EV_TOUCH_DOWN, 1'b0);
                n++;
                trk_touched = 1'b1;
            end
        end
        else
        begin
            // full release, second_down does not matter here
            if (trk_pinched)
            begin
                trk_pinched = 1'b0;
                trk_bx = bx;
                trk_by = by;
                evs[n] = snap(EV_PINCH_UP, 1'b1);
                n++;
            end
            if (trk_touched)
            begin
                trk_touched = 1'b0;
                trk_ax = ax;
                trk_ay = ay;
                evs[n] = snap(EV_TOUCH_UP, 1'b0);
                n++;
            end
        end
        if (n > 0)
            evs[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            gestures_due.push_back(evs[i]);
    endtask

    // prediction first, then the check, so a same-edge pair cannot race
    always @(posedge clk)
    begin : watch_ports
        gesture_t want;
        irq_t     taken;
        irq_fire = rst_n && push && !full;
        if (irq_fire)
        begin
            taken = '{first_down, second_down, first_x, first_y, second_x, second_y};
            irqs_taken++;
            track_gesture(taken);
        end
        if (rst_n && pop && !empty)
        begin
            if (gestures_due.size() == 0)
                report_mismatch("event with none due, kind", int'(event_kind), -1);
            else
            begin
                want = gestures_due.pop_front();
                events_checked++;
                kind_hits[int'(want.kind)]++;
                if (event_kind != want.kind)
                    report_mismatch("event_kind", int'(event_kind), int'(want.kind));
                if (pos_a_x != want.ax)
                    report_mismatch("pos_a_x", int'(pos_a_x), int'(want.ax));
                if (pos_a_y != want.ay)
                    report_mismatch("pos_a_y", int'(pos_a_y), int'(want.ay));
                if (pos_b_x != want.bx)
                    report_mismatch("pos_b_x", int'(pos_b_x), int'(want.bx));
                if (pos_b_y != want.by)
                    report_mismatch("pos_b_y", int'(pos_b_y), int'(want.by));
                if (last_of_run != want.last)
                    report_mismatch("last_of_run", int'(last_of_run), int'(want.last));
            end
        end
    end

    // a word stays on the ports until it is taken
    always @(negedge clk)
    begin : drive_irq
        irq_t nxt;
        if (!rst_n)
            push <= 1'b0;
        else if (!push || irq_fire)
        begin
            if (irq_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = irq_backlog.pop_front();
                push        <= 1'b1;
                first_down  <= nxt.d1;
                second_down <= nxt.d2;
                first_x     <= nxt.ax;
                first_y     <= nxt.ay;
                second_x    <= nxt.bx;
                second_y    <= nxt.by;
            end
            else
                push <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left <= HOLD_CYCLES;
            hold_req  <= 1'b0;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic queue_irq(input logic d1, input logic d2, input coord_t ax,
                             input coord_t ay, input coord_t bx, input coord_t by);
        irq_t w;
        w = '{d1, d2, ax, ay, bx, by};
        irq_backlog.push_back(w);
        irqs_queued++;
    endtask

    function automatic coord_t any_coord();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return coord_t'(COORD_TOP);
            default: return coord_t'($urandom_range(0, COORD_TOP));
        endcase
    endfunction

    // small move, sometimes none at all
    function automatic coord_t nudge(input coord_t c);
        int v;
        v = int'(c) + int'($urandom_range(0, 6)) - 3;
        if (v < 0)
            v = 0;
        if (v > COORD_TOP)
            v = COORD_TOP;
        return coord_t'(v);
    endfunction

    task automatic add_stroke();
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        bit     pinch_first;
        bit     released;
        ax = any_coord();
        ay = any_coord();
        pinch_first = ($urandom_range(0, 4) == 0);
        released = 1'b0;
        if (!pinch_first)
        begin
            queue_irq(1'b1, 1'b0, ax, ay, any_coord(), any_coord());
            repeat ($urandom_range(0, 5))
            begin
                ax = nudge(ax);
                ay = nudge(ay);
                queue_irq(1'b1, 1'b0, ax, ay, any_coord(), any_coord());
            end
        end
        if (pinch_first || $urandom_range(0, 1))
        begin
            bx = any_coord();
            by = any_coord();
            queue_irq(1'b1, 1'b1, ax, ay, bx, by);
            repeat ($urandom_range(0, 5))
            begin
                ax = nudge(ax);
                ay = nudge(ay);
                bx = nudge(bx);
                by = nudge(by);
                queue_irq(1'b1, 1'b1, ax, ay, bx, by);
            end
            if ($urandom_range(0, 1))
                queue_irq(1'b1, 1'b0, nudge(ax), nudge(ay), any_coord(), any_coord());
            else
            begin
                queue_irq(1'b0, 1'($urandom_range(0, 1)), any_coord(), any_coord(),
                          any_coord(), any_coord());
                released = 1'b1;
            end
        end
        if (!released)
        begin
            repeat ($urandom_range(0, 3))
            begin
                ax = nudge(ax);
                ay = nudge(ay);
                queue_irq(1'b1, 1'b0, ax, ay, any_coord(), any_coord());
            end
            queue_irq(1'b0, 1'($urandom_range(0, 1)), any_coord(), any_coord(),
                      any_coord(), any_coord());
        end
    endtask

    task automatic add_random(input int target);
        while (irqs_queued < target)
        begin
            if ($urandom_range(0, 9) < 8)
                add_stroke();
            else
                repeat ($urandom_range(1, 3))
                    queue_irq(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              any_coord(), any_coord(), any_coord(), any_coord());
        end
    endtask

    task automatic drain();
        while (irqs_taken != irqs_queued || gestures_due.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        first_down    = 1'b0;
        second_down   = 1'b0;
        first_x       = '0;
        first_y       = '0;
        second_x      = '0;
        second_y      = '0;
        trk_touched   = 1'b0;
        trk_pinched   = 1'b0;
        trk_ax        = '0;
        trk_ay        = '0;
        trk_bx        = '0;
        trk_by        = '0;
        hold_req      = 1'b0;
        hold_left     = 0;
        send_idle_pct = 33;
        recv_idle_pct = 56;

        // directed words: idle release, touch path, pinch paths, both releases
        queue_irq(1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0);
        queue_irq(1'b1, 1'b0, 12'd0, 12'd0, 12'd4095, 12'd4095);
        queue_irq(1'b1, 1'b0, 12'd0, 12'd0, 12'd17, 12'd17);
        queue_irq(1'b1, 1'b0, 12'd4095, 12'd4095, 12'd0, 12'd0);
        queue_irq(1'b1, 1'b0, 12'd4095, 12'd0, 12'd0, 12'd0);
        queue_irq(1'b0, 1'b1, 12'd123, 12'd4095, 12'd7, 12'd7);
        queue_irq(1'b1, 1'b1, 12'd4095, 12'd4095, 12'd0, 12'd0);
        queue_irq(1'b1, 1'b1, 12'd4095, 12'd4095, 12'd0, 12'd0);
        queue_irq(1'b1, 1'b1, 12'd4095, 12'd4095, 12'd4095, 12'd0);
        queue_irq(1'b1, 1'b1, 12'd4095, 12'd0, 12'd4095, 12'd0);
        queue_irq(1'b1, 1'b0, 12'd1, 12'd1, 12'd2048, 12'd2047);
        queue_irq(1'b1, 1'b0, 12'd5, 12'd5, 12'd0, 12'd0);
        queue_irq(1'b1, 1'b1, 12'd6, 12'd6, 12'd4095, 12'd4095);
        queue_irq(1'b0, 1'b0, 12'd0, 12'd4095, 12'd4095, 12'd0);
        queue_irq(1'b1, 1'b0, 12'd4095, 12'd0, 12'd0, 12'd0);
        queue_irq(1'b1, 1'b1, 12'd4095, 12'd0, 12'd0, 12'd4095);
        queue_irq(1'b1, 1'b0, 12'd100, 12'd200, 12'd300, 12'd400);
        queue_irq(1'b1, 1'b0, 12'd100, 12'd200, 12'd0, 12'd0);
        queue_irq(1'b0, 1'b0, 12'd2730, 12'd1365, 12'd0, 12'd0);
        queue_irq(1'b1, 1'b1, 12'd1, 12'd2, 12'd3, 12'd4);
        queue_irq(1'b0, 1'b1, 12'd9, 12'd9, 12'd2730, 12'd1365);
        queue_irq(1'b0, 1'b1, 12'd4095, 12'd4095, 12'd4095, 12'd4095);

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        add_random(480);
        drain();
        @(posedge clk);
        send_idle_pct = 56;
        recv_idle_pct = 33;

        add_random(930);
        drain();
        @(posedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // long pop stall while words keep coming, so full must rise
        add_random(1350);
        @(negedge clk);
        hold_req = 1'b1;
        drain();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (gestures_due.size() != 0)
            report_mismatch("events still due at end", 0, gestures_due.size());

        $display("covered %0d interrupts and %0d events: touch down/drag/up %0d/%0d/%0d,",
                 irqs_taken, events_checked, kind_hits[0], kind_hits[1], kind_hits[2]);
        $display("pinch down/drag/up %0d/%0d/%0d, three idle mixes, one %0d-cycle pop stall",
                 kind_hits[3], kind_hits[4], kind_hits[5], HOLD_CYCLES);
        if (errors == 0)
            $display("tb_touch_gesture_tracker_unit OK");
        else
            $display("tb_touch_gesture_tracker_unit NOT OK");
        $finish;
    end

endmodule
